// ===== src/napot_region_slot_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// napot region slot allocator assertion macros
// shared property forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef NAPOT_REGION_SLOT_ALLOCATOR_DEFINES_SVH
`define NAPOT_REGION_SLOT_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define NRSA_ASSERT_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("nrsa assertion failed");

// next-cycle implication, disabled during reset
`define NRSA_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("nrsa assertion failed");

`endif

// ===== src/nrsa_pkg.sv =====
// ----------------------------------------------------------------------------
// nrsa_pkg
// shared constants for the napot region slot allocator
// ----------------------------------------------------------------------------
package nrsa_pkg;

    localparam int SLOT_COUNT_DEF = 16;

    localparam int S_TDATA_W = 128;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 3;

    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_PRESENT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ATTR    = 1'd1;

    localparam logic [0:0] MODE_SET  = 1'b0;
    localparam logic [0:0] MODE_FREE = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ABSENT   = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_BADSIZE  = 3'd4;

    localparam logic [31:0] MIN_SIZE = 32'd8;
    localparam logic [5:0]  NAPOT_SHIFT = 6'd3;

endpackage

// ===== src/napot_region_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// napot_region_slot_allocator
// region table with napot address encoding and lowest-free-slot allocation
// ----------------------------------------------------------------------------
// channel   dir  tdata                                  tuser
// s_        in   base[31:0] tag[95:32] size[127:96]     mode[0]
// m_        out  slot[3:0] word[35:4] attr[43:36]       status[2:0]
// cfg_wr_   in   write enable, register index, data     -
//
// a set passes capture, prep, a log pass (4 bits, then 1 bit a cycle, then a
// step to leave), a scan of up to SLOT_COUNT slots and output; a free skips
// the log pass, and a set that is absent or too small goes straight to output.
// the scan reads one tag store word a cycle through a registered read port and
// one comparator checks it. reset clears the slot valid bits at once, no
// clearing pass. a stalled result waits in the output register.
// ----------------------------------------------------------------------------
module napot_region_slot_allocator #(
    parameter int SLOT_COUNT = nrsa_pkg::SLOT_COUNT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // phys_base, owner_tag, region_size
    input  logic [nrsa_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode
    input  logic [nrsa_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // slot, napot_word, attr_byte, zero pad
    output logic [nrsa_pkg::M_TDATA_W-1:0]   m_tdata,
    // status
    output logic [nrsa_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                             cfg_wr_en,
    input  logic [nrsa_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [nrsa_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SLOT_COUNT);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_LOG  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [63:0] tag_mem  [SLOT_COUNT];
    logic [7:0]  attr_mem [SLOT_COUNT];
    logic [31:0] addr_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] tag_vld_reg, tag_vld_next;

    logic [2:0]  state_reg, state_next;
    logic        mode_reg, mode_next;
    logic [31:0] base_reg, base_next;
    logic [63:0] tag_reg, tag_next;
    logic [31:0] size_reg, size_next;
    logic [32:0] val_reg, val_next;
    logic [5:0]  pow_reg, pow_next;
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             cmp_pend_reg, cmp_pend_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [63:0]      rd_data_reg;
    logic             rd_vld_reg;

    logic [2:0]  res_status_reg, res_status_next;
    logic [3:0]  res_slot_reg, res_slot_next;
    logic [31:0] res_word_reg, res_word_next;
    logic [7:0]  res_attr_reg, res_attr_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [2:0]  m_status_reg;
    logic [3:0]  m_slot_reg;
    logic [31:0] m_word_reg;
    logic [7:0]  m_attr_reg;

    logic        present_reg, present_next;
    logic [7:0]  attr_cfg_reg, attr_cfg_next;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [63:0]      cur_tag;
    logic [63:0]      target_tag;
    logic             hit;
    logic             set_wr;
    logic             free_wr;
    logic             out_load;
    logic [31:0]      size_m1;
    logic             misaligned;
    logic [5:0]       k_full;
    logic [4:0]       k;
    logic [31:0]      ones;
    logic [31:0]      word_c;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, m_attr_reg, m_word_reg, m_slot_reg};
    assign m_tuser  = m_status_reg;

    assign rd_addr    = rd_cnt_reg[IDX_W-1:0];
    assign cur_tag    = rd_vld_reg ? rd_data_reg : 64'd0;
    assign target_tag = (mode_reg == nrsa_pkg::MODE_FREE) ? tag_reg : 64'd0;
    assign hit        = (state_reg == S_SCAN) && cmp_pend_reg && (cur_tag == target_tag);
    assign rd_en      = (state_reg == S_SCAN) && !hit && (rd_cnt_reg < CNT_END);
    assign set_wr     = hit && (mode_reg == nrsa_pkg::MODE_SET);
    assign free_wr    = hit && (mode_reg == nrsa_pkg::MODE_FREE);
    assign out_load   = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    assign size_m1    = size_reg - 32'd1;
    assign misaligned = |(base_reg & size_m1);

    // bits below k set, bit k clear
    assign k_full = pow_reg - nrsa_pkg::NAPOT_SHIFT;
    assign k      = k_full[4:0];
    assign ones   = ~(32'hFFFF_FFFF << k);
    assign word_c = ({2'b00, base_reg[31:2]} | ones) & ~(32'd1 << k);

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        base_next       = base_reg;
        tag_next        = tag_reg;
        size_next       = size_reg;
        val_next        = val_reg;
        pow_next        = pow_reg;
        rd_cnt_next     = rd_cnt_reg;
        cmp_pend_next   = rd_en;
        cmp_idx_next    = rd_en ? rd_addr : cmp_idx_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_word_next   = res_word_reg;
        res_attr_next   = res_attr_reg;
        tag_vld_next    = tag_vld_reg;
        present_next    = present_reg;
        attr_cfg_next   = attr_cfg_reg;
        m_tvalid_next   = m_tready ? 1'b0 : m_tvalid_reg;

        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                nrsa_pkg::CFG_PRESENT: present_next  = cfg_wr_data[0];
                nrsa_pkg::CFG_ATTR:    attr_cfg_next = cfg_wr_data;
                default:               present_next  = present_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    mode_next  = s_tuser[0];
                    base_next  = s_tdata[31:0];
                    tag_next   = s_tdata[95:32];
                    size_next  = s_tdata[127:96];
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                res_status_next = nrsa_pkg::ST_OK;
                res_slot_next   = 4'd0;
                res_word_next   = 32'd0;
                res_attr_next   = 8'd0;
                rd_cnt_next     = '0;
                pow_next        = 6'd0;
                priority if (mode_reg == nrsa_pkg::MODE_FREE) begin
                    state_next = S_SCAN;
                end else if (!present_reg) begin
                    res_status_next = nrsa_pkg::ST_ABSENT;
                    state_next      = S_OUT;
                end else if (size_reg < nrsa_pkg::MIN_SIZE) begin
                    res_status_next = nrsa_pkg::ST_BADSIZE;
                    state_next      = S_OUT;
                end else begin
                    if (misaligned) begin
                        base_next = base_reg & ~size_m1;
                        val_next  = {size_reg, 1'b0};
                    end else begin
                        val_next  = {1'b0, size_reg};
                    end
                    state_next = S_LOG;
                end
            end
            S_LOG: begin
                priority if (|val_reg[32:4]) begin
                    val_next = val_reg >> 4;
                    pow_next = pow_reg + 6'd4;
                end else if (|val_reg[32:1]) begin
                    val_next = val_reg >> 1;
                    pow_next = pow_reg + 6'd1;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                priority if (hit) begin
                    res_slot_next = 4'(cmp_idx_reg);
                    if (mode_reg == nrsa_pkg::MODE_SET) begin
                        res_word_next             = word_c;
                        res_attr_next             = attr_cfg_reg;
                        tag_vld_next[cmp_idx_reg] = 1'b1;
                    end else begin
                        tag_vld_next[cmp_idx_reg] = 1'b0;
                    end
                    state_next = S_OUT;
                end else if (cmp_pend_reg && (cmp_idx_reg == LAST_IDX)) begin
                    res_status_next = (mode_reg == nrsa_pkg::MODE_FREE) ?
                                      nrsa_pkg::ST_NOTFOUND : nrsa_pkg::ST_FULL;
                    state_next      = S_OUT;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cmp_pend_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            tag_vld_reg  <= '0;
            present_reg  <= 1'b1;
            attr_cfg_reg <= 8'd0;
        end else begin
            state_reg    <= state_next;
            cmp_pend_reg <= cmp_pend_next;
            m_tvalid_reg <= m_tvalid_next;
            tag_vld_reg  <= tag_vld_next;
            present_reg  <= present_next;
            attr_cfg_reg <= attr_cfg_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        base_reg       <= base_next;
        tag_reg        <= tag_next;
        size_reg       <= size_next;
        val_reg        <= val_next;
        pow_reg        <= pow_next;
        rd_cnt_reg     <= rd_cnt_next;
        cmp_idx_reg    <= cmp_idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_word_reg   <= res_word_next;
        res_attr_reg   <= res_attr_next;
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
            m_word_reg   <= res_word_reg;
            m_attr_reg   <= res_attr_reg;
        end
    end

    // tag store read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= tag_mem[rd_addr];
            rd_vld_reg  <= tag_vld_reg[rd_addr];
        end
    end

    // region table write port
    always_ff @(posedge aclk) begin
        if (set_wr) begin
            tag_mem[cmp_idx_reg]  <= tag_reg;
            attr_mem[cmp_idx_reg] <= attr_cfg_reg;
            addr_mem[cmp_idx_reg] <= word_c;
        end else if (free_wr) begin
            attr_mem[cmp_idx_reg] <= 8'd0;
        end
    end

endmodule

// ===== src/nrsa_checker.sv =====
// ----------------------------------------------------------------------------
// nrsa_checker
// port-level checks for the napot region slot allocator
// ----------------------------------------------------------------------------
`include "napot_region_slot_allocator_defines.svh"

module nrsa_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [nrsa_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [nrsa_pkg::M_TUSER_W-1:0] m_tuser
);

    // stalled result word holds
    `NRSA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // status is always a defined code
    `NRSA_ASSERT_SAME(a_status_code, m_tvalid, m_tuser <= nrsa_pkg::ST_BADSIZE)

    // a failed request carries no slot, word or attribute
    `NRSA_ASSERT_SAME(a_fail_zero, m_tvalid && (m_tuser != nrsa_pkg::ST_OK), m_tdata == '0)

    // one request at a time: busy right after an accept
    `NRSA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

endmodule

bind napot_region_slot_allocator nrsa_checker u_nrsa_checker (.*);
